// ----- hw/rtl/egsa_pkg.sv -----
// Shared types, codes and sizes of the embedding gradient scatter-accumulate engine.
`default_nettype none
package egsa_pkg;

  localparam int unsigned DEF_MAX_ROWS  = 1024;
  localparam int unsigned DEF_MAX_COLS  = 64;
  localparam int unsigned DEF_ACC_WIDTH = 40;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned CNT_W      = 16;

  // Command codes.
  localparam logic [1:0] CMD_ACC = 2'd0;
  localparam logic [1:0] CMD_RD  = 2'd1;
  localparam logic [1:0] CMD_CLR = 2'd2;
  localparam logic [1:0] CMD_BAD = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_PAD = 2'd1;
  localparam logic [1:0] ST_RNG = 2'd2;
  localparam logic [1:0] ST_SAT = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PAD   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COLS  = 2'd3;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [9:0]         row_index;
    logic [5:0]         column;
    logic signed [31:0] grad_value;
  } egsa_in_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [1:0]         status;
  } egsa_out_t;

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_RD, S_CALC, S_DIV, S_FIN, S_DONE
  } egsa_state_t;

  typedef struct packed {
    logic clr;
    logic load;
    logic rd;
    logic calc;
    logic div_step;
    logic fin;
    logic out_load;
  } egsa_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic need_div;
    logic div_last;
    logic out_free;
  } egsa_stat_t;

endpackage
`default_nettype wire

// ----- hw/rtl/embedding_grad_scatter_accumulate.sv -----
// Top level of the embedding gradient scatter-accumulate engine.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid/in_ready    egsa_in_t  (cmd, row, column, gradient)
//   out_     output     out_valid/out_ready  egsa_out_t (result value, status)
//   cfg_     input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Each transaction is handled alone: accept, a store read, an execute step, then a load
// into the output register (states S_IDLE, S_RD, S_CALC, S_DONE). A scaled read passes
// through the bit-serial divider (S_DIV) and a final step (S_FIN) before S_DONE. After
// reset a clearing pass writes zero to every accumulator and use counter, all
// MAX_ROWS*MAX_COLS entries (65536 by default), with in_ready low; configuration
// writes are taken throughout. A finished result waits in the output register, and the
// next transaction is accepted meanwhile; only a second finished result stalls behind it.
`default_nettype none
module embedding_grad_scatter_accumulate import egsa_pkg::*; #(
  parameter int unsigned MAX_ROWS  = DEF_MAX_ROWS,
  parameter int unsigned MAX_COLS  = DEF_MAX_COLS,
  parameter int unsigned ACC_WIDTH = DEF_ACC_WIDTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire egsa_in_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output egsa_out_t                  out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  egsa_cmd_t  cmd;
  egsa_stat_t stat;

  // Configuration registers take a write in any cycle.
  assign cfg_ready = 1'b1;

  egsa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  egsa_dp #(
    .MAX_ROWS  (MAX_ROWS),
    .MAX_COLS  (MAX_COLS),
    .ACC_WIDTH (ACC_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  // An accepted transaction occupies the engine for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted twice in consecutive cycles");

  // The clearing pass keeps the input closed right after reset.
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input open during clearing pass");

  // A result cannot appear in the cycle right after an accept.
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result appeared too early");
`endif

endmodule
`default_nettype wire

// ----- hw/rtl/egsa_ctrl.sv -----
// Controller state machine of the gradient engine.
`default_nettype none
module egsa_ctrl import egsa_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire egsa_stat_t stat,
  output egsa_cmd_t       cmd
);

  egsa_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLR:  if (stat.clr_last) state_nxt = S_IDLE;
      S_IDLE: if (in_valid) state_nxt = S_RD;
      S_RD:   state_nxt = S_CALC;
      S_CALC: state_nxt = stat.need_div ? S_DIV : S_DONE;
      S_DIV:  if (stat.div_last) state_nxt = S_FIN;
      S_FIN:  state_nxt = S_DONE;
      S_DONE: if (stat.out_free) state_nxt = S_IDLE;
      default: state_nxt = S_CLR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_CLR:  cmd.clr = 1'b1;
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_RD:   cmd.rd = 1'b1;
      S_CALC: cmd.calc = 1'b1;
      S_DIV:  cmd.div_step = 1'b1;
      S_FIN:  cmd.fin = 1'b1;
      S_DONE: cmd.out_load = stat.out_free;
      default: cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

// ----- hw/rtl/egsa_dp.sv -----
// Datapath of the gradient engine: registers, stores, adder, divider, output register.
`default_nettype none
module egsa_dp import egsa_pkg::*; #(
  parameter int unsigned MAX_ROWS  = DEF_MAX_ROWS,
  parameter int unsigned MAX_COLS  = DEF_MAX_COLS,
  parameter int unsigned ACC_WIDTH = DEF_ACC_WIDTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire egsa_cmd_t             cmd,
  output egsa_stat_t                 stat,
  input  wire egsa_in_t              in_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  out_ready,
  output logic                       out_valid,
  output egsa_out_t                  out_data
);

  localparam int unsigned DEPTH = MAX_ROWS * MAX_COLS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned RW    = $clog2(MAX_ROWS);
  localparam int unsigned DCW   = $clog2(ACC_WIDTH + 1);
  localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};
  localparam logic signed [ACC_WIDTH-1:0] I32_MAX = ACC_WIDTH'(32'sh7fffffff);
  localparam logic signed [ACC_WIDTH-1:0] I32_MIN = ACC_WIDTH'(-33'sh80000000);

  // Configuration registers.
  logic signed [10:0] pad_r;
  logic               scale_r;
  logic [10:0]        rows_r;
  logic [6:0]         cols_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pad_r   <= -11'sd1;
      scale_r <= 1'b0;
      rows_r  <= 11'd1024;
      cols_r  <= 7'd64;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PAD:   pad_r   <= cfg_data;
        REG_SCALE: scale_r <= cfg_data[0];
        REG_ROWS:  rows_r  <= cfg_data;
        REG_COLS:  cols_r  <= cfg_data[6:0];
        default:   pad_r   <= pad_r;
      endcase
    end
  end

  // Item registers, loaded at accept.
  egsa_in_t        item_r;
  logic            bad_r;
  logic [AW-1:0]   addr_r;
  logic [RW-1:0]   row_r;
  logic [16:0]     rlim;
  logic [10:0]     clim;
  logic            bad_nxt;
  logic [31:0]     addr_full;

  always_comb begin
    rlim = (17'(rows_r) < 17'(MAX_ROWS)) ? 17'(rows_r) : 17'(MAX_ROWS);
    clim = (32'(cols_r) < MAX_COLS) ? 11'(cols_r) : 11'(MAX_COLS);
    bad_nxt = (in_data.cmd == CMD_BAD) || (17'(in_data.row_index) >= rlim)
              || (11'(in_data.column) >= clim);
    addr_full = 32'(in_data.row_index) * 32'(MAX_COLS) + 32'(in_data.column);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_data;
      bad_r  <= bad_nxt;
      addr_r <= addr_full[AW-1:0];
      row_r  <= RW'(in_data.row_index);
    end
  end

  // Stores and their registered reads.
  logic [ACC_WIDTH-1:0] acc_mem [DEPTH];
  logic [CNT_W-1:0]     cnt_mem [MAX_ROWS];
  logic signed [ACC_WIDTH-1:0] acc_q_r;
  logic [CNT_W-1:0]     cnt_q_r;
  logic [AW-1:0]        clr_addr_r;

  logic                 acc_we, cnt_we;
  logic [AW-1:0]        acc_wa;
  logic [RW-1:0]        cnt_wa;
  logic [ACC_WIDTH-1:0] acc_wd;
  logic [CNT_W-1:0]     cnt_wd;

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      acc_q_r <= acc_mem[addr_r];
      cnt_q_r <= cnt_mem[row_r];
    end
  end

  always_ff @(posedge clk) begin
    if (acc_we) acc_mem[acc_wa] <= acc_wd;
  end

  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clr) begin
      clr_addr_r <= clr_addr_r + AW'(1);
    end
  end

  // Execute step.
  logic [ACC_WIDTH:0]          sum;
  logic signed [ACC_WIDTH-1:0] sum_sat;
  logic                        sum_ovf;
  logic                        pad_hit;
  logic                        col0;
  logic signed [31:0]          calc_res;
  logic [1:0]                  calc_st;
  logic                        rd_sat;
  logic signed [31:0]          rd_res;
  logic signed [ACC_WIDTH-1:0] sat_in;
  logic signed [31:0]          sat_out;
  logic                        sat_flag;

  always_comb begin
    sum     = {acc_q_r[ACC_WIDTH-1], acc_q_r} + (ACC_WIDTH+1)'(item_r.grad_value);
    sum_ovf = sum[ACC_WIDTH] != sum[ACC_WIDTH-1];
    sum_sat = sum_ovf ? (sum[ACC_WIDTH] ? ACC_MIN : ACC_MAX) : sum[ACC_WIDTH-1:0];
    pad_hit = pad_r == $signed({1'b0, item_r.row_index});
    col0    = item_r.column == 6'd0;
  end

  // Divider registers.
  logic [ACC_WIDTH-1:0] dvd_r;
  logic [CNT_W-1:0]     rem_r;
  logic [CNT_W-1:0]     den_r;
  logic [DCW-1:0]       div_cnt_r;
  logic                 neg_r;
  logic [CNT_W:0]       rem_sh;
  logic                 ge;
  logic [CNT_W:0]       rem_sub;
  logic [ACC_WIDTH-1:0] quo;

  always_comb begin
    sat_in = cmd.fin ? $signed(quo) : acc_q_r;
    if (sat_in > I32_MAX) begin
      sat_out  = 32'sh7fffffff;
      sat_flag = 1'b1;
    end else if (sat_in < I32_MIN) begin
      sat_out  = 32'sh80000000;
      sat_flag = 1'b1;
    end else begin
      sat_out  = sat_in[31:0];
      sat_flag = 1'b0;
    end
    rd_res = sat_out;
    rd_sat = sat_flag;
  end

  always_comb begin
    acc_we   = 1'b0;
    cnt_we   = 1'b0;
    acc_wa   = addr_r;
    cnt_wa   = row_r;
    acc_wd   = '0;
    cnt_wd   = '0;
    calc_res = '0;
    calc_st  = ST_OK;
    if (cmd.clr) begin
      acc_we = 1'b1;
      acc_wa = clr_addr_r;
      cnt_we = 32'(clr_addr_r) < MAX_ROWS;
      cnt_wa = RW'(clr_addr_r);
    end else if (cmd.calc) begin
      if (bad_r) begin
        calc_st = ST_RNG;
      end else begin
        case (item_r.cmd)
          CMD_ACC: begin
            cnt_we = col0 && (cnt_q_r != '1);
            cnt_wd = cnt_q_r + CNT_W'(1);
            if (pad_hit) begin
              calc_st = ST_PAD;
            end else begin
              acc_we  = 1'b1;
              acc_wd  = sum_sat;
              calc_st = sum_ovf ? ST_SAT : ST_OK;
            end
          end
          CMD_RD: begin
            calc_res = rd_res;
            calc_st  = rd_sat ? ST_SAT : ST_OK;
          end
          default: begin
            acc_we = 1'b1;
            cnt_we = col0;
          end
        endcase
      end
    end
  end

  assign stat.need_div = !bad_r && (item_r.cmd == CMD_RD) && scale_r && (cnt_q_r > CNT_W'(1));
  assign stat.div_last = div_cnt_r == DCW'(1);
  assign stat.clr_last = clr_addr_r == AW'(DEPTH - 1);
  assign stat.out_free = !out_valid || out_ready;

  // Restoring divider on the magnitude, one quotient bit per cycle.
  always_comb begin
    rem_sh  = {rem_r, dvd_r[ACC_WIDTH-1]};
    ge      = rem_sh >= {1'b0, den_r};
    rem_sub = rem_sh - {1'b0, den_r};
    quo     = neg_r ? (~dvd_r + ACC_WIDTH'(1)) : dvd_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      dvd_r     <= acc_q_r[ACC_WIDTH-1] ? (~acc_q_r + ACC_WIDTH'(1)) : acc_q_r;
      neg_r     <= acc_q_r[ACC_WIDTH-1];
      rem_r     <= '0;
      den_r     <= cnt_q_r;
      div_cnt_r <= DCW'(ACC_WIDTH);
    end else if (cmd.div_step) begin
      rem_r     <= ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
      dvd_r     <= {dvd_r[ACC_WIDTH-2:0], ge};
      div_cnt_r <= div_cnt_r - DCW'(1);
    end
  end

  // Result holding register and output register.
  egsa_out_t res_r;
  logic      out_valid_r;
  egsa_out_t out_r;

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      res_r.result_value <= calc_res;
      res_r.status       <= calc_st;
    end else if (cmd.fin) begin
      res_r.result_value <= rd_res;
      res_r.status       <= rd_sat ? ST_SAT : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) out_r <= res_r;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

// ----- sim/testbench.sv -----
// Self-checking testbench for the embedding gradient scatter-accumulate engine.
`default_nettype none
module testbench import egsa_pkg::*; ();

  localparam int unsigned ROWS = DEF_MAX_ROWS;
  localparam int unsigned COLS = DEF_MAX_COLS;
  localparam longint ACC_HI = (64'sd1 <<< (DEF_ACC_WIDTH - 1)) - 1;
  localparam longint ACC_LO = -ACC_HI - 1;
  localparam longint CYCLE_LIMIT = 900000;

  // Scoreboard: a private copy of the engine state plus the queue of pending results.
  class grad_scoreboard;
    longint    acc_mem[int];
    int        use_cnt[int];
    int        pad_row;
    bit        freq_scale;
    int        row_lim;
    int        col_lim;
    egsa_out_t pending_q[$];
    int        errors;
    int        results_seen;

    function new();
      pad_row = -1;
      freq_scale = 0;
      row_lim = 1024;
      col_lim = 64;
      errors = 0;
      results_seen = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_PAD: begin
          pad_row = int'($signed(val));
        end
        REG_SCALE: begin
          freq_scale = val[0];
        end
        REG_ROWS: begin
          row_lim = int'(val);
        end
        default: begin
          col_lim = int'(val[6:0]);
        end
      endcase
    endfunction

    // Work out the result of one accepted transaction and update the state copy.
    function void note_input(egsa_in_t t);
      egsa_out_t r;
      int        addr;
      int        rl;
      int        cl;
      longint    a;
      longint    g;
      longint    v;
      int        cnt;
      r.result_value = 0;
      r.status = ST_OK;
      rl = (row_lim < ROWS) ? row_lim : ROWS;
      cl = (col_lim < COLS) ? col_lim : COLS;
      addr = t.row_index * COLS + t.column;
      g = longint'(t.grad_value);
      if (t.cmd == CMD_BAD || t.row_index >= rl || t.column >= cl) begin
        r.status = ST_RNG;
      end else if (t.cmd == CMD_ACC) begin
        cnt = use_cnt.exists(t.row_index) ? use_cnt[t.row_index] : 0;
        if (t.column == 0 && cnt != 65535) use_cnt[t.row_index] = cnt + 1;
        if (int'(t.row_index) == pad_row) begin
          r.status = ST_PAD;
        end else begin
          a = acc_mem.exists(addr) ? acc_mem[addr] : 0;
          if (g > 0 && a > ACC_HI - g) begin
            a = ACC_HI;
            r.status = ST_SAT;
          end else if (g < 0 && a < ACC_LO - g) begin
            a = ACC_LO;
            r.status = ST_SAT;
          end else begin
            a = a + g;
          end
          acc_mem[addr] = a;
        end
      end else if (t.cmd == CMD_RD) begin
        v = acc_mem.exists(addr) ? acc_mem[addr] : 0;
        cnt = use_cnt.exists(t.row_index) ? use_cnt[t.row_index] : 0;
        if (freq_scale && cnt > 1) v = v / cnt;
        if (v > 64'sd2147483647) begin
          v = 64'sd2147483647;
          r.status = ST_SAT;
        end else if (v < -64'sd2147483648) begin
          v = -64'sd2147483648;
          r.status = ST_SAT;
        end
        r.result_value = v[31:0];
      end else begin
        acc_mem[addr] = 0;
        if (t.column == 0) use_cnt[t.row_index] = 0;
      end
      pending_q.push_back(r);
    endfunction

    task check_result(egsa_out_t got);
      egsa_out_t exp_r;
      results_seen++;
      if (pending_q.size() == 0) begin
        report_mismatch("result with nothing pending", 0, got.status);
        return;
      end
      exp_r = pending_q.pop_front();
      if (got.result_value !== exp_r.result_value)
        report_mismatch("result_value", exp_r.result_value, got.result_value);
      if (got.status !== exp_r.status)
        report_mismatch("status", exp_r.status, got.status);
    endtask

    task report_mismatch(string what, longint want, longint seen);
      errors++;
      if (errors <= 40)
        $display("mismatch in %s: expected %0d, got %0d (result %0d)",
                 what, want, seen, results_seen);
    endtask
  endclass

  logic                  clk = 0;
  logic                  rst_n = 0;
  logic                  in_valid = 0;
  logic                  in_ready;
  egsa_in_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 0;
  egsa_out_t             out_data;
  logic                  cfg_valid = 0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  grad_scoreboard sb = new();
  longint         cycle_count = 0;
  bit             quiet_tail = 0;
  int             grads_sent = 0;

  always #6 clk = ~clk;

  embedding_grad_scatter_accumulate dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Watchdog: its limit must also cover the clearing pass after reset.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Result side: accepted transactions are checked in order; ready stalls in bursts.
  always @(posedge clk) begin
    int burst;
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
    if (!quiet_tail && $urandom_range(0, 9) == 0) begin
      burst = $urandom_range(1, 19);
      out_ready <= 0;
      repeat (burst) @(posedge clk) begin
        if (rst_n && out_valid && out_ready) sb.check_result(out_data);
      end
    end
    out_ready <= 1;
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, val);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  // Sends one transaction; valid stays high across back-to-back sends.
  task automatic send_grad(logic [1:0] c, int r, int col, logic [31:0] g);
    egsa_in_t t;
    int       gap;
    if (!quiet_tail && $urandom_range(0, 11) == 0) begin
      gap = $urandom_range(1, 19);
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    t.cmd = c;
    t.row_index = 10'(r);
    t.column = 6'(col);
    t.grad_value = g;
    in_data  <= t;
    in_valid <= 1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(t);
    grads_sent++;
  endtask

  // Waits for every pending result, then lets the divider run out before config changes.
  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // Random traffic concentrated on a few rows so reads see accumulated values.
  task automatic random_phase(int n);
    int        r;
    int        col;
    int        pick;
    logic [31:0] g;
    logic [1:0]  c;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      r = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 7);
      col = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 3);
      if (pick < 50) c = CMD_ACC;
      else if (pick < 85) c = CMD_RD;
      else if (pick < 96) c = CMD_CLR;
      else c = CMD_BAD;
      case ($urandom_range(0, 3))
        0: g = $urandom();
        1: g = {{16{1'b0}}, 16'($urandom())};
        2: g = $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
        default: g = 32'($signed(16'($urandom())));
      endcase
      send_grad(c, r, col, g);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1;

    // Directed: extremes, every command, padding, range checks.
    send_grad(CMD_ACC, 0, 0, 32'h7fffffff);
    send_grad(CMD_ACC, 0, 0, 32'h7fffffff);
    send_grad(CMD_RD, 0, 0, 0);
    send_grad(CMD_ACC, 1023, 63, 32'h80000000);
    send_grad(CMD_RD, 1023, 63, 0);
    send_grad(CMD_BAD, 5, 5, 32'h12345678);
    send_grad(CMD_CLR, 0, 0, 0);
    send_grad(CMD_RD, 0, 0, 0);
    // Hammer one accumulator into the 40-bit saturation region.
    for (int i = 0; i < 260; i++) send_grad(CMD_ACC, 2, 1, 32'h7fffffff);
    send_grad(CMD_RD, 2, 1, 0);
    for (int i = 0; i < 520; i++) send_grad(CMD_ACC, 2, 1, 32'h80000000);
    send_grad(CMD_RD, 2, 1, 0);
    drain();

    write_reg(REG_PAD, 11'd3);
    write_reg(REG_SCALE, 11'd1);
    write_reg(REG_ROWS, 11'd8);
    write_reg(REG_COLS, 11'd4);
    send_grad(CMD_ACC, 3, 0, 32'h00010000);
    send_grad(CMD_ACC, 3, 1, 32'h00010000);
    send_grad(CMD_RD, 3, 1, 0);
    send_grad(CMD_ACC, 8, 0, 1);
    send_grad(CMD_ACC, 1, 4, 1);
    send_grad(CMD_ACC, 4, 0, 32'hfffffff9);
    send_grad(CMD_ACC, 4, 0, 0);
    send_grad(CMD_RD, 4, 0, 0);
    send_grad(CMD_RD, 2, 1, 0);
    random_phase(200);
    drain();

    write_reg(REG_PAD, 11'h7fe);
    write_reg(REG_SCALE, 11'd0);
    write_reg(REG_ROWS, 11'd0);
    write_reg(REG_COLS, 11'd0);
    send_grad(CMD_ACC, 0, 0, 1);
    send_grad(CMD_RD, 0, 0, 0);
    drain();

    write_reg(REG_ROWS, 11'd1024);
    write_reg(REG_COLS, 11'd64);
    write_reg(REG_PAD, 11'd0);
    random_phase(200);
    drain();

    write_reg(REG_PAD, 11'h7ff);
    write_reg(REG_SCALE, 11'd1);
    write_reg(REG_ROWS, 11'h7ff);
    write_reg(REG_COLS, 11'h7f);
    random_phase(200);
    quiet_tail = 1;
    random_phase(100);
    drain();

    $display("sent %0d transactions across five register settings, %0d results checked",
             grads_sent, sb.results_seen);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ----- files.f -----
hw/rtl/egsa_pkg.sv
hw/rtl/egsa_ctrl.sv
hw/rtl/egsa_dp.sv
hw/rtl/embedding_grad_scatter_accumulate.sv
sim/testbench.sv
